### hdl/mbrfc_pkg.sv
package mbrfc_pkg;

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;
  localparam logic [8:0]  PosMax  = 9'd511;

  localparam int unsigned SizeLimit    = 256;
  localparam int unsigned RespOverhead = 5;
  localparam int unsigned CoilByteMax  = SizeLimit - RespOverhead;

  localparam logic [7:0] FC_READ_COILS      = 8'd1;
  localparam logic [7:0] FC_READ_DISCRETE   = 8'd2;
  localparam logic [7:0] FC_READ_HOLDING    = 8'd3;
  localparam logic [7:0] FC_READ_INPUT      = 8'd4;
  localparam logic [7:0] FC_WRITE_COIL      = 8'd5;
  localparam logic [7:0] FC_WRITE_REG       = 8'd6;
  localparam logic [7:0] FC_WRITE_COILS     = 8'd15;
  localparam logic [7:0] FC_WRITE_REGS      = 8'd16;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_BAD_CRC    = 3'd1;
  localparam logic [2:0] ST_BAD_FUNC   = 3'd2;
  localparam logic [2:0] ST_ADDR_RANGE = 3'd3;
  localparam logic [2:0] ST_QTY_LARGE  = 3'd4;
  localparam logic [2:0] ST_SHORT      = 3'd5;

  localparam logic [0:0] REG_REGISTER_COUNT = 1'b0;

  typedef struct packed {
    logic [15:0] crc;
    logic [15:0] held;
    logic [7:0]  func;
    logic [15:0] addr;
    logic [15:0] qty;
    logic        short_frame;
  } frame_rec_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

### hdl/mbrfc_in_if.sv
interface mbrfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       last_byte;

  modport source (output valid, output frame_byte, output last_byte, input ready);
  modport sink (input valid, input frame_byte, input last_byte, output ready);
endinterface

### hdl/mbrfc_out_if.sv
interface mbrfc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [7:0]  function_code;
  logic [15:0] errors_seen;

  modport source (output valid, output status, output function_code, output errors_seen,
                  input ready);
  modport sink (input valid, input status, input function_code, input errors_seen,
                output ready);
endinterface

### hdl/mbrfc_tracker.sv
module mbrfc_tracker
  import mbrfc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  mbrfc_in_if.sink   in_i,
  output frame_rec_t rec_o,
  output logic       rec_valid_o,
  input  logic       rec_ready_i
);

  logic [15:0] crc_q, crc_d;
  logic [8:0]  pos_q, pos_inc;
  logic [15:0] held_q, held_d;
  logic [7:0]  func_q, func_d;
  logic [15:0] addr_q, addr_d;
  logic [15:0] qty_q, qty_d;
  logic [15:0] base_crc, base_held, base_addr, base_qty;
  logic [7:0]  base_func;
  frame_rec_t  rec_q;
  logic        rec_valid_q;
  logic        accept;
  logic        first;

  assign in_i.ready  = !rec_valid_q || rec_ready_i;
  assign accept      = in_i.valid && in_i.ready;
  assign rec_o       = rec_q;
  assign rec_valid_o = rec_valid_q;
  assign first       = (pos_q == 9'd0);

  always_comb begin
    base_crc  = first ? CrcInit : crc_q;
    base_held = first ? 16'h0000 : held_q;
    base_func = first ? 8'h00 : func_q;
    base_addr = first ? 16'h0000 : addr_q;
    base_qty  = first ? 16'h0000 : qty_q;

    crc_d  = (pos_q >= 9'd2) ? crc_feed(base_crc, base_held[15:8]) : base_crc;
    held_d = {base_held[7:0], in_i.frame_byte};
    func_d = (pos_q == 9'd1) ? in_i.frame_byte : base_func;
    addr_d = base_addr;
    qty_d  = base_qty;
    if (pos_q == 9'd2) addr_d = {in_i.frame_byte, base_addr[7:0]};
    if (pos_q == 9'd3) addr_d = {base_addr[15:8], in_i.frame_byte};
    if (pos_q == 9'd4) qty_d  = {in_i.frame_byte, base_qty[7:0]};
    if (pos_q == 9'd5) qty_d  = {base_qty[15:8], in_i.frame_byte};

    pos_inc = (pos_q == PosMax) ? PosMax : pos_q + 9'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q       <= CrcInit;
      pos_q       <= 9'd0;
      held_q      <= 16'h0000;
      func_q      <= 8'h00;
      addr_q      <= 16'h0000;
      qty_q       <= 16'h0000;
      rec_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        pos_q  <= in_i.last_byte ? 9'd0 : pos_inc;
        crc_q  <= in_i.last_byte ? CrcInit : crc_d;
        held_q <= held_d;
        func_q <= func_d;
        addr_q <= addr_d;
        qty_q  <= qty_d;
      end
      if (accept && in_i.last_byte) begin
        rec_valid_q <= 1'b1;
      end else if (rec_ready_i) begin
        rec_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && in_i.last_byte) begin
      rec_q <= '{crc: crc_d, held: held_d, func: func_d, addr: addr_d, qty: qty_d,
                 short_frame: (pos_q < 9'd3)};
    end
  end

  a_pos_clear_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_i.last_byte |=> pos_q == 9'd0)
    else $error("frame position not cleared after final byte");

  a_crc_init_at_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q == 9'd0 |-> crc_q == CrcInit)
    else $error("crc not at init value at frame start");

endmodule

### hdl/mbrfc_checker.sv
module mbrfc_checker
  import mbrfc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [15:0] register_count_i,
  input  frame_rec_t  rec_i,
  input  logic        rec_valid_i,
  output logic        rec_ready_o,
  mbrfc_out_if.source out_o
);

  logic        out_valid_q;
  logic [2:0]  status_q, status_d, range_status;
  logic [7:0]  func_out_q;
  logic [15:0] tally_q, tally_d;
  logic        take;
  logic        crc_ok, func_ok, bump;
  logic [15:0] rx_crc;
  logic [16:0] lim;
  logic [16:0] coil_span, single_span, reg_span;
  logic [13:0] coil_bytes;
  logic [17:0] reg_bytes;

  assign rec_ready_o = !out_valid_q || out_o.ready;
  assign take        = rec_valid_i && rec_ready_o;

  assign out_o.valid         = out_valid_q;
  assign out_o.status        = status_q;
  assign out_o.function_code = func_out_q;
  assign out_o.errors_seen   = tally_q;

  always_comb begin
    rx_crc  = {rec_i.held[7:0], rec_i.held[15:8]};
    crc_ok  = (rx_crc == rec_i.crc);
    func_ok = (rec_i.func == FC_READ_COILS) || (rec_i.func == FC_READ_DISCRETE) ||
              (rec_i.func == FC_READ_HOLDING) || (rec_i.func == FC_READ_INPUT) ||
              (rec_i.func == FC_WRITE_COIL) || (rec_i.func == FC_WRITE_REG) ||
              (rec_i.func == FC_WRITE_COILS) || (rec_i.func == FC_WRITE_REGS);

    lim         = {1'b0, register_count_i};
    coil_span   = 17'(rec_i.addr[15:4]) + 17'(rec_i.qty[15:4]) + 17'(|rec_i.qty[3:0]);
    coil_bytes  = 14'(rec_i.qty[15:3]) + 14'(|rec_i.qty[2:0]);
    single_span = 17'(rec_i.addr[15:4]) + 17'(|rec_i.addr[3:0]);
    reg_span    = 17'(rec_i.addr) + 17'(rec_i.qty);
    reg_bytes   = 18'({rec_i.qty, 1'b0}) + 18'(RespOverhead);

    unique case (rec_i.func)
      FC_READ_COILS, FC_READ_DISCRETE, FC_WRITE_COILS: begin
        if (coil_span > lim) range_status = ST_ADDR_RANGE;
        else if (coil_bytes > 14'(CoilByteMax)) range_status = ST_QTY_LARGE;
        else range_status = ST_OK;
      end
      FC_WRITE_COIL: begin
        range_status = (single_span > lim) ? ST_ADDR_RANGE : ST_OK;
      end
      FC_WRITE_REG: begin
        range_status = (lim < {1'b0, rec_i.addr}) ? ST_ADDR_RANGE : ST_OK;
      end
      default: begin
        if (reg_span > lim) range_status = ST_ADDR_RANGE;
        else if (reg_bytes > 18'(SizeLimit)) range_status = ST_QTY_LARGE;
        else range_status = ST_OK;
      end
    endcase

    bump = 1'b0;
    if (rec_i.short_frame) begin
      status_d = ST_SHORT;
    end else if (!crc_ok) begin
      status_d = ST_BAD_CRC;
      bump     = 1'b1;
    end else if (!func_ok) begin
      status_d = ST_BAD_FUNC;
      bump     = 1'b1;
    end else begin
      status_d = range_status;
    end

    tally_d = (bump && (tally_q != 16'hFFFF)) ? tally_q + 16'd1 : tally_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      tally_q     <= 16'h0000;
    end else begin
      if (take) begin
        out_valid_q <= 1'b1;
        tally_q     <= tally_d;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      status_q   <= status_d;
      func_out_q <= rec_i.func;
    end
  end

  a_tally_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ##1 tally_q >= $past(tally_q))
    else $error("error counter went down");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> status_q <= ST_SHORT)
    else $error("status code out of range");

endmodule

### hdl/modbus_request_frame_checker.sv
// Checks Modbus RTU request frames fed one byte per transfer, with last_byte set on
// the final byte. A byte is taken in every cycle unless a stalled result holds it off.
// Each frame gives one result. The crc update and field capture act on the incoming
// byte, and at the final byte they land in a frame record register. The status
// checks sit between that record and the result register. A stalled result holds
// off new bytes only once both registers are full. The result holds status (ok,
// bad crc, unsupported function, address range, quantity too large, short frame),
// the function code and a saturating count of crc and function errors.
// register_count sits at byte address 0 of the APB port and should only be
// written while no frame is in flight.
module modbus_request_frame_checker
  import mbrfc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  mbrfc_in_if.sink    in_i,
  mbrfc_out_if.source out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0] register_count_q;
  frame_rec_t  rec;
  logic        rec_valid;
  logic        rec_ready;
  logic        sel_count;

  assign pready    = 1'b1;
  assign sel_count = (paddr[2] == REG_REGISTER_COUNT);
  assign prdata    = sel_count ? {16'h0000, register_count_q} : 32'h0000_0000;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      register_count_q <= 16'hFFFF;
    end else if (psel && penable && pwrite && pready && sel_count) begin
      register_count_q <= pwdata[15:0];
    end
  end

  mbrfc_tracker u_tracker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .rec_o       (rec),
    .rec_valid_o (rec_valid),
    .rec_ready_i (rec_ready)
  );

  mbrfc_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .register_count_i (register_count_q),
    .rec_i            (rec),
    .rec_valid_i      (rec_valid),
    .rec_ready_o      (rec_ready),
    .out_o            (out_o)
  );

endmodule
